>>> hw/rtl/rebf_pkg.sv
// ----------------------------------------------------------------------------
// rebf_pkg
// Shared types and constants for the row edge box finder.
// ----------------------------------------------------------------------------
package rebf_pkg;

    localparam int PIX_W   = 24;   // one stored pixel, red high, blue low
    localparam int LIM_W   = 19;   // (threshold + 1)^2 fits in 19 bits
    localparam int SUM_W   = 18;   // three 16-bit squares summed
    localparam int BOX_W   = 16;   // signed working width of box arithmetic
    localparam int ROWS_W  = 11;
    localparam int COORD_W = 10;

    localparam logic [10:0] COLUMNS_RST   = 11'd640;
    localparam logic [10:0] ROWS_RST      = 11'd480;
    localparam logic [8:0]  THRESHOLD_RST = 9'd25;
    localparam logic [7:0]  MARGIN_RST    = 8'd15;

    typedef enum logic [1:0] {
        CFG_COLUMNS   = 2'd0,
        CFG_ROWS      = 2'd1,
        CFG_THRESHOLD = 2'd2,
        CFG_MARGIN    = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_L,
        ST_SCAN_R,
        ST_BOX,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       req_type;
        logic [9:0] pixel_column;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] seed_x;
        logic [9:0] seed_y;
    } t_in;

    typedef struct packed {
        logic [9:0] box_left;
        logic [9:0] box_top;
        logic [9:0] box_right;
        logic [9:0] box_bottom;
    } t_out;

    // Control outputs of the sequencer
    typedef struct packed {
        logic in_ready;
        logic scanning;
        logic box_en;
        logic out_load;
    } t_ctrl;

endpackage

>>> hw/rtl/rebf_row_store.sv
// ----------------------------------------------------------------------------
// rebf_row_store
// Single-row pixel memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rebf_row_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [rebf_pkg::PIX_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [rebf_pkg::PIX_W-1:0] o_rdata
);

    logic [rebf_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [rebf_pkg::PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/rebf_grad.sv
// ----------------------------------------------------------------------------
// rebf_grad
// Colour gradient test of two neighbour pixels: squares registered, then
// summed and compared against (threshold + 1) squared.
// ----------------------------------------------------------------------------
module rebf_grad (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rebf_pkg::PIX_W-1:0] i_a,
    input  logic [rebf_pkg::PIX_W-1:0] i_b,
    input  logic [rebf_pkg::LIM_W-1:0] i_lim,
    output logic                       o_edge
);

    logic [7:0]  s_dr, s_dg, s_db;
    logic [15:0] r_sq_r, r_sq_g, r_sq_b;
    logic [rebf_pkg::SUM_W-1:0] s_sum;

    always_comb begin
        s_dr = (i_a[23:16] >= i_b[23:16]) ? i_a[23:16] - i_b[23:16] : i_b[23:16] - i_a[23:16];
        s_dg = (i_a[15:8] >= i_b[15:8]) ? i_a[15:8] - i_b[15:8] : i_b[15:8] - i_a[15:8];
        s_db = (i_a[7:0] >= i_b[7:0]) ? i_a[7:0] - i_b[7:0] : i_b[7:0] - i_a[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_r <= 16'(s_dr) * 16'(s_dr);
            r_sq_g <= 16'(s_dg) * 16'(s_dg);
            r_sq_b <= 16'(s_db) * 16'(s_db);
        end
    end

    assign s_sum  = rebf_pkg::SUM_W'(r_sq_r) + rebf_pkg::SUM_W'(r_sq_g)
                  + rebf_pkg::SUM_W'(r_sq_b);
    assign o_edge = rebf_pkg::LIM_W'(s_sum) >= i_lim;

endmodule

>>> hw/rtl/rebf_box.sv
// ----------------------------------------------------------------------------
// rebf_box
// Box arithmetic: raw bounds registered, then clamped to image and field.
// ----------------------------------------------------------------------------
module rebf_box #(
    parameter int AW = 10,
    parameter int CW = 11
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [AW-1:0]               i_xmin,
    input  logic [CW-1:0]               i_xmax,
    input  logic [CW-1:0]               i_cols,
    input  logic [rebf_pkg::ROWS_W-1:0] i_rows,
    input  logic [9:0]                  i_sy,
    input  logic [7:0]                  i_margin,
    output rebf_pkg::t_out              o_box
);

    localparam int BW = rebf_pkg::BOX_W;

    logic signed [BW-1:0] s_xmin, s_xmax, s_w, s_half, s_sy, s_cols, s_rows_m1;
    logic signed [BW-1:0] s_left, s_right, s_top, s_bot;
    logic signed [BW-1:0] r_left, r_right, r_top, r_bot;
    logic                 r_full;
    logic signed [BW-1:0] s_l, s_r, s_t, s_b;

    function automatic logic [9:0] cap10(input logic signed [BW-1:0] v);
        if (v < 0) begin
            return 10'd0;
        end else if (v > 1023) begin
            return 10'd1023;
        end
        return v[9:0];
    endfunction

    always_comb begin
        s_xmin    = signed'(BW'(i_xmin));
        s_xmax    = signed'(BW'(i_xmax));
        s_sy      = signed'(BW'(i_sy));
        s_cols    = signed'(BW'(i_cols));
        s_rows_m1 = signed'(BW'(i_rows)) - BW'(1);
        s_w       = s_xmax - s_xmin;
        s_half    = (s_w + BW'(1)) >>> 1;
        s_top     = s_sy - s_half;
        s_bot     = s_sy + s_w;
        s_left    = s_xmin - signed'(BW'(i_margin));
        s_right   = s_xmax + signed'(BW'(i_margin));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_left  <= s_left;
            r_right <= s_right;
            r_top   <= s_top;
            r_bot   <= s_bot;
            r_full  <= (s_left < 0) || (s_right >= s_cols);
        end
    end

    // A clamped side opens the box to the full height
    always_comb begin
        s_l = (r_left < 0) ? '0 : r_left;
        s_r = (r_right >= s_cols) ? s_cols - BW'(1) : r_right;
        if (r_full) begin
            s_t = '0;
            s_b = s_rows_m1;
        end else begin
            s_t = (r_top < 0) ? '0 : r_top;
            s_b = (r_bot > s_rows_m1) ? s_rows_m1 : r_bot;
        end
        o_box.box_left   = cap10(s_l);
        o_box.box_top    = cap10(s_t);
        o_box.box_right  = cap10(s_r);
        o_box.box_bottom = cap10(s_b);
    end

endmodule

>>> hw/rtl/row_edge_box_finder_top.sv
// Pixel load: accepted while idle, no result; loads may follow back to back.
// Query: each walk reads one column a cycle from the seed to the pixel past its
// edge (or to the row end) and ends when the gradient test of that pixel
// reports; the left walk goes first. After the right walk ends the result
// passes the box register and the output register. New requests wait.
// Reset: registers to 640/480/25/15 columns/rows/threshold/margin; store not cleared.
// ----------------------------------------------------------------------------
// row_edge_box_finder_top
// Row store, edge walk sequencer and box builder with a registered output.
// ----------------------------------------------------------------------------
module row_edge_box_finder_top #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [10:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rebf_pkg::t_in      i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rebf_pkg::t_out     o_out
);

    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int CW = $clog2(MAX_COLUMNS + 1);

    // configuration
    logic [10:0] r_columns;
    logic [10:0] r_rows;
    logic [8:0]  r_threshold;
    logic [7:0]  r_margin;
    logic [rebf_pkg::LIM_W-1:0] r_lim;
    logic [9:0]  s_t1;
    logic [19:0] s_lim_prod;

    logic [CW-1:0] s_cols;
    logic [10:0]   s_rows;

    rebf_pkg::t_state r_state, n_state;
    rebf_pkg::t_ctrl  s_ctrl;

    logic          s_in_acc, s_load_we, s_query;
    logic [AW-1:0] s_seed;

    // walk pipeline
    logic [AW-1:0] r_sx;
    logic [9:0]    r_sy;
    logic [AW-1:0] r_addr;
    logic          r_issue_v, r_first;
    logic          s_last;
    logic          r_v1, r_first1, r_last1;
    logic [AW-1:0] r_col1;
    logic          r_v2, r_pair2, r_last2;
    logic [AW-1:0] r_col2;
    logic [rebf_pkg::PIX_W-1:0] s_rdata, r_prev;
    logic          s_edge, s_hit, s_stop;

    logic [AW-1:0] r_xmin;
    logic [CW-1:0] r_xmax;

    rebf_pkg::t_out s_box, r_out;
    logic           r_out_valid;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns   <= rebf_pkg::COLUMNS_RST;
            r_rows      <= rebf_pkg::ROWS_RST;
            r_threshold <= rebf_pkg::THRESHOLD_RST;
            r_margin    <= rebf_pkg::MARGIN_RST;
        end else if (i_cfg_we) begin
            unique case (rebf_pkg::t_cfg_idx'(i_cfg_idx))
                rebf_pkg::CFG_COLUMNS:   r_columns   <= i_cfg_data;
                rebf_pkg::CFG_ROWS:      r_rows      <= i_cfg_data;
                rebf_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[8:0];
                rebf_pkg::CFG_MARGIN:    r_margin    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign s_t1       = 10'(r_threshold) + 10'd1;
    assign s_lim_prod = 20'(s_t1) * 20'(s_t1);

    always_ff @(posedge i_clk) begin
        r_lim <= s_lim_prod[rebf_pkg::LIM_W-1:0];
    end

    always_comb begin
        if (r_columns < 11'd2) begin
            s_cols = CW'(2);
        end else if (int'(r_columns) > MAX_COLUMNS) begin
            s_cols = CW'(MAX_COLUMNS);
        end else begin
            s_cols = CW'(r_columns);
        end
        s_rows = (r_rows == 11'd0) ? 11'd1 : r_rows;
    end

    // ---------------------------------------------------------------- input
    assign o_in_ready = s_ctrl.in_ready;
    assign s_in_acc   = i_in_valid && s_ctrl.in_ready;
    assign s_query    = s_in_acc && (rebf_pkg::t_req'(i_in.req_type) == rebf_pkg::REQ_QUERY);
    assign s_load_we  = s_in_acc && (rebf_pkg::t_req'(i_in.req_type) == rebf_pkg::REQ_LOAD)
                      && (int'(i_in.pixel_column) < MAX_COLUMNS);
    assign s_seed     = (int'(i_in.seed_x) > int'(s_cols) - 1) ? AW'(s_cols - CW'(1))
                                                               : AW'(i_in.seed_x);

    rebf_row_store #(
        .DEPTH (MAX_COLUMNS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_load_we),
        .i_waddr (AW'(i_in.pixel_column)),
        .i_wdata ({i_in.red, i_in.green, i_in.blue}),
        .i_re    (r_issue_v),
        .i_raddr (r_addr),
        .o_rdata (s_rdata)
    );

    rebf_grad u_grad (
        .i_clk  (i_clk),
        .i_en   (r_v1),
        .i_a    (s_rdata),
        .i_b    (r_prev),
        .i_lim  (r_lim),
        .o_edge (s_edge)
    );

    // ---------------------------------------------------------------- walk
    assign s_last = (r_state == rebf_pkg::ST_SCAN_L) ? (r_addr == '0)
                  : (CW'(r_addr) == s_cols - CW'(1));
    assign s_hit  = r_pair2 && s_edge;
    assign s_stop = s_ctrl.scanning && r_v2 && (s_hit || r_last2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_v <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
        end else begin
            if (s_query) begin
                r_issue_v <= 1'b1;
            end else if (s_stop) begin
                // restart from the seed for the right walk, else finish
                r_issue_v <= (r_state == rebf_pkg::ST_SCAN_L);
            end else if (r_issue_v && s_last) begin
                r_issue_v <= 1'b0;
            end
            r_v1 <= r_issue_v && !s_stop;
            r_v2 <= r_v1 && !s_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_query) begin
            r_sx    <= s_seed;
            r_sy    <= i_in.seed_y;
            r_addr  <= s_seed;
            r_first <= 1'b1;
        end else if (s_stop) begin
            r_addr  <= r_sx;
            r_first <= 1'b1;
        end else if (r_issue_v) begin
            r_first <= 1'b0;
            if (!s_last) begin
                r_addr <= (r_state == rebf_pkg::ST_SCAN_L) ? r_addr - AW'(1)
                                                           : r_addr + AW'(1);
            end
        end
        r_col1   <= r_addr;
        r_first1 <= r_first;
        r_last1  <= s_last;
        if (r_v1) begin
            r_prev <= s_rdata;
        end
        r_col2  <= r_col1;
        r_pair2 <= !r_first1;
        r_last2 <= r_last1;
        if (s_stop) begin
            if (r_state == rebf_pkg::ST_SCAN_L) begin
                r_xmin <= s_hit ? r_col2 + AW'(1) : '0;
            end else begin
                r_xmax <= s_hit ? CW'(r_col2 - AW'(1)) : s_cols;
            end
        end
    end

    // ---------------------------------------------------------------- box
    rebf_box #(
        .AW (AW),
        .CW (CW)
    ) u_box (
        .i_clk    (i_clk),
        .i_en     (s_ctrl.box_en),
        .i_xmin   (r_xmin),
        .i_xmax   (r_xmax),
        .i_cols   (s_cols),
        .i_rows   (s_rows),
        .i_sy     (r_sy),
        .i_margin (r_margin),
        .o_box    (s_box)
    );

    // ---------------------------------------------------------------- fsm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rebf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rebf_pkg::ST_IDLE: begin
                if (s_query) n_state = rebf_pkg::ST_SCAN_L;
            end
            rebf_pkg::ST_SCAN_L: begin
                if (s_stop) n_state = rebf_pkg::ST_SCAN_R;
            end
            rebf_pkg::ST_SCAN_R: begin
                if (s_stop) n_state = rebf_pkg::ST_BOX;
            end
            rebf_pkg::ST_BOX: begin
                n_state = rebf_pkg::ST_EMIT;
            end
            rebf_pkg::ST_EMIT: begin
                if (s_ctrl.out_load) n_state = rebf_pkg::ST_IDLE;
            end
            default: n_state = rebf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ctrl = '0;
        unique case (r_state)
            rebf_pkg::ST_IDLE:   s_ctrl.in_ready = 1'b1;
            rebf_pkg::ST_SCAN_L: s_ctrl.scanning = 1'b1;
            rebf_pkg::ST_SCAN_R: s_ctrl.scanning = 1'b1;
            rebf_pkg::ST_BOX:    s_ctrl.box_en   = 1'b1;
            rebf_pkg::ST_EMIT:   s_ctrl.out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ctrl.out_load) begin
            r_out <= s_box;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row edge box finder testbench
// Loads painted pixel rows and issues box queries through the request
// channel, predicts each box from a private copy of the row and registers,
// and checks every result in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ROW_DEPTH  = 1024;
    localparam int SETTLE_CYC = 16;
    localparam int RX_HOLD    = 400;
    localparam int PHASE_REQS = 8;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic [1:0]     i_cfg_idx = '0;
    logic [10:0]    i_cfg_data = '0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    rebf_pkg::t_in  i_in = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    rebf_pkg::t_out o_out;

    row_edge_box_finder_top #(
        .MAX_COLUMNS(ROW_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    always #6 i_clk = ~i_clk;

    // Shadow of the register file and the row store
    logic [10:0] cfg_columns   = 11'd640;
    logic [10:0] cfg_rows      = 11'd480;
    logic [8:0]  cfg_threshold = 9'd25;
    logic [7:0]  cfg_margin    = 8'd15;
    logic [23:0] row_copy [ROW_DEPTH];
    bit          planned [ROW_DEPTH];

    rebf_pkg::t_in  queued_requests [$];
    rebf_pkg::t_out expected_boxes [$];

    int   errors = 0;
    int   issued = 0;
    int   cyc = 0;
    bit   steady;
    bit   req_taken = 1'b0;
    bit   rx_hold_wanted = 1'b0;
    int   rx_hold_left = 0;
    logic [23:0] paint_colour = '0;

    assign steady = (cyc % 3000) >= 2400;

    always @(posedge i_clk) cyc++;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int eff_columns();
        int c;
        c = int'(cfg_columns);
        if (c < 2) c = 2;
        if (c > ROW_DEPTH) c = ROW_DEPTH;
        return c;
    endfunction

    function automatic bit is_colour_step(logic [23:0] a, logic [23:0] b);
        int dr, dg, db, t;
        dr = int'(a[23:16]) - int'(b[23:16]);
        dg = int'(a[15:8]) - int'(b[15:8]);
        db = int'(a[7:0]) - int'(b[7:0]);
        t = int'(cfg_threshold);
        return (dr * dr + dg * dg + db * db) >= (t + 1) * (t + 1);
    endfunction

    function automatic logic [9:0] clip_coord(int v);
        if (v < 0) return 10'd0;
        if (v > 1023) return 10'd1023;
        return v[9:0];
    endfunction

    function automatic rebf_pkg::t_out predict_box(rebf_pkg::t_in rq);
        int             cols, rows, sx, sy, i, lo_edge, hi_edge, w, top, bot;
        bit             hit;
        rebf_pkg::t_out b;
        cols = eff_columns();
        rows = (cfg_rows == 0) ? 1 : int'(cfg_rows);
        sx = int'(rq.seed_x);
        if (sx > cols - 1) sx = cols - 1;
        sy = int'(rq.seed_y);
        lo_edge = 0;
        hit = 1'b0;
        for (i = sx; i > 0; i--)
            if (!hit && is_colour_step(row_copy[i], row_copy[i - 1])) begin
                lo_edge = i;
                hit = 1'b1;
            end
        hi_edge = cols;
        hit = 1'b0;
        for (i = sx; i < cols - 1; i++)
            if (!hit && is_colour_step(row_copy[i], row_copy[i + 1])) begin
                hi_edge = i;
                hit = 1'b1;
            end
        w = hi_edge - lo_edge;
        top = sy - (w + 1) / 2;
        bot = sy + w;
        lo_edge -= int'(cfg_margin);
        hi_edge += int'(cfg_margin);
        // a clamped side widens the box to the full image height
        if (lo_edge < 0) begin
            lo_edge = 0;
            top = 0;
            bot = rows - 1;
        end
        if (hi_edge >= cols) begin
            hi_edge = cols - 1;
            top = 0;
            bot = rows - 1;
        end
        if (top < 0) top = 0;
        if (bot >= rows) bot = rows - 1;
        b.box_left   = clip_coord(lo_edge);
        b.box_top    = clip_coord(top);
        b.box_right  = clip_coord(hi_edge);
        b.box_bottom = clip_coord(bot);
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Request driver and intake
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (queued_requests.size() == 0 || (!steady && $urandom_range(99) < 35)) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_in <= queued_requests[0];
            end
        end
    end

    always @(posedge i_clk) begin
        req_taken = i_rst_n && i_in_valid && o_in_ready;
        if (req_taken) begin
            void'(queued_requests.pop_front());
            if (i_in.req_type == rebf_pkg::REQ_QUERY) begin
                expected_boxes.push_back(predict_box(i_in));
            end else begin
                row_copy[i_in.pixel_column] = {i_in.red, i_in.green, i_in.blue};
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver and checker
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_hold_wanted) begin
            rx_hold_wanted = 1'b0;
            rx_hold_left = RX_HOLD;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(99) >= 35);
        end
    end

    always @(posedge i_clk) begin
        rebf_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_boxes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected box l=%0d t=%0d r=%0d b=%0d", $realtime,
                             o_out.box_left, o_out.box_top, o_out.box_right,
                             o_out.box_bottom);
            end else begin
                want = expected_boxes.pop_front();
                if (o_out.box_left !== want.box_left || o_out.box_top !== want.box_top ||
                    o_out.box_right !== want.box_right ||
                    o_out.box_bottom !== want.box_bottom) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: box want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 $realtime, want.box_left, want.box_top, want.box_right,
                                 want.box_bottom, o_out.box_left, o_out.box_top,
                                 o_out.box_right, o_out.box_bottom);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [7:0] move_channel(logic [7:0] v, int d);
        int r;
        r = int'(v) + d;
        if (r < 0) r = 0;
        if (r > 255) r = 255;
        return r[7:0];
    endfunction

    function automatic logic [23:0] next_colour(logic [23:0] prev, int amp);
        logic [23:0] c;
        int k, step, d;
        k = $urandom_range(99);
        c = prev;
        if (k < 15) begin
            c = 24'($urandom);
        end else if (k < 23) begin
            // sit right on the threshold, or one above it
            step = int'(cfg_threshold) + int'($urandom_range(1));
            if (step <= 255) begin
                case ($urandom_range(2))
                    0: begin
                        d = (int'(c[23:16]) + step <= 255) ? step : -step;
                        c[23:16] = move_channel(c[23:16], d);
                    end
                    1: begin
                        d = (int'(c[15:8]) + step <= 255) ? step : -step;
                        c[15:8] = move_channel(c[15:8], d);
                    end
                    default: begin
                        d = (int'(c[7:0]) + step <= 255) ? step : -step;
                        c[7:0] = move_channel(c[7:0], d);
                    end
                endcase
            end
        end else begin
            c[23:16] = move_channel(c[23:16], int'($urandom_range(2 * amp)) - amp);
            c[15:8]  = move_channel(c[15:8], int'($urandom_range(2 * amp)) - amp);
            c[7:0]   = move_channel(c[7:0], int'($urandom_range(2 * amp)) - amp);
        end
        return c;
    endfunction

    task automatic push_load(int col, logic [23:0] colour);
        rebf_pkg::t_in rq;
        rq = '0;
        rq.req_type = rebf_pkg::REQ_LOAD;
        rq.pixel_column = col[9:0];
        {rq.red, rq.green, rq.blue} = colour;
        rq.seed_x = 10'($urandom);
        rq.seed_y = 10'($urandom);
        planned[col] = 1'b1;
        queued_requests.push_back(rq);
        issued++;
    endtask

    task automatic push_query(int sx, int sy);
        rebf_pkg::t_in rq;
        rq.req_type = rebf_pkg::REQ_QUERY;
        rq.pixel_column = 10'($urandom);
        rq.red = 8'($urandom);
        rq.green = 8'($urandom);
        rq.blue = 8'($urandom);
        rq.seed_x = sx[9:0];
        rq.seed_y = sy[9:0];
        queued_requests.push_back(rq);
        issued++;
    endtask

    task automatic paint_run(int start, int len, int amp, bit fresh_only);
        int c;
        for (c = start; c < start + len && c < ROW_DEPTH; c++) begin
            paint_colour = next_colour(paint_colour, amp);
            if (!fresh_only || !planned[c]) push_load(c, paint_colour);
        end
    endtask

    function automatic int pick_seed(int s, int len);
        int k;
        k = $urandom_range(99);
        if (k < 60) return s + int'($urandom_range(len - 1));
        if (k < 80) return int'($urandom_range(eff_columns() - 1));
        if (k < 90) return 1023;
        return 0;
    endfunction

    function automatic int pick_row();
        int k;
        k = $urandom_range(99);
        if (k < 10) return 0;
        if (k < 20) return 1023;
        return int'($urandom_range(1023));
    endfunction

    task automatic write_reg(rebf_pkg::t_cfg_idx idx, int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[10:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            rebf_pkg::CFG_COLUMNS:   cfg_columns = value[10:0];
            rebf_pkg::CFG_ROWS:      cfg_rows = value[10:0];
            rebf_pkg::CFG_THRESHOLD: cfg_threshold = value[8:0];
            rebf_pkg::CFG_MARGIN:    cfg_margin = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int cols, int rows, int thr, int margin);
        write_reg(rebf_pkg::CFG_COLUMNS, cols);
        write_reg(rebf_pkg::CFG_ROWS, rows);
        write_reg(rebf_pkg::CFG_THRESHOLD, thr);
        write_reg(rebf_pkg::CFG_MARGIN, margin);
    endtask

    task automatic wait_drained();
        while (queued_requests.size() != 0 || expected_boxes.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int p, cols, rows, thr, margin, amp, start_count, s, len, k, n;
        bit paused;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of all four registers; the whole row must be loaded first
        paint_run(0, eff_columns() + 4, 8, 1'b1);
        repeat (12) push_query(pick_seed(0, eff_columns()), pick_row());
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);

        // Directed: threshold borders, channel extremes, seed and row extremes
        set_config(12, 2047, 4, 0);
        push_load(0, 24'h000000);
        push_load(1, 24'h000000);
        push_load(2, 24'h050000);
        push_load(3, 24'h050000);
        push_load(4, 24'h090300);
        push_load(5, 24'h0c0501);
        push_load(6, 24'h0c0505);
        push_load(7, 24'hffffff);
        push_load(8, 24'h000000);
        push_load(9, 24'hff00ff);
        push_load(10, 24'h00ff00);
        push_load(11, 24'h00ff00);
        push_query(0, 0);
        push_query(1023, 1023);
        push_query(5, 1023);
        push_query(6, 0);
        push_query(3, 500);
        push_query(10, 7);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        // threshold past the largest distance: no step is ever seen
        set_config(12, 2047, 511, 255);
        push_query(3, 1023);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        // column and row counts below their floors
        set_config(0, 0, 0, 0);
        push_query(1023, 500);
        push_query(0, 0);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);

        // Random phases, the widest rows last
        for (p = 0; p < 12; p++) begin
            case (p)
                0:  begin cols = 32;   rows = 64;   thr = 10;  margin = 3;   end
                1:  begin cols = 2;    rows = 1;    thr = 0;   margin = 0;   end
                2:  begin cols = 100;  rows = 1024; thr = 60;  margin = 255; end
                3:  begin cols = 640;  rows = 200;  thr = 441; margin = 8;   end
                4:  begin cols = 64;   rows = 2047; thr = 25;  margin = 15;  end
                5:  begin cols = 8;    rows = 10;   thr = 1;   margin = 1;   end
                8:  begin cols = 300;  rows = 1023; thr = 200; margin = 128; end
                10: begin cols = 1024; rows = 512;  thr = 5;   margin = 31;  end
                11: begin cols = 2047; rows = 1024; thr = 511; margin = 0;   end
                default: begin
                    cols = $urandom_range(2, 200);
                    rows = $urandom_range(1, 1024);
                    thr = $urandom_range(120);
                    margin = $urandom_range(40);
                end
            endcase
            set_config(cols, rows, thr, margin);
            amp = (thr > 120) ? 40 : thr / 3;
            cols = eff_columns();
            paint_run(0, cols + 4, amp, 1'b1);
            if (p == 2) rx_hold_wanted = 1'b1;
            start_count = issued;
            paused = 1'b0;
            while (issued - start_count < PHASE_REQS) begin
                k = $urandom_range(99);
                if (k < 65) begin
                    s = $urandom_range(cols - 1);
                    len = $urandom_range(1, (cols - s < 24) ? cols - s : 24);
                    paint_run(s, len, amp, 1'b0);
                    n = $urandom_range(1, 3);
                    repeat (n) push_query(pick_seed(s, len), pick_row());
                end else if (k < 85) begin
                    push_query($urandom_range(1023), pick_row());
                end else begin
                    push_load($urandom_range(ROW_DEPTH - 1), 24'($urandom));
                end
                // hold the sender until every box so far has come back
                if (p == 4 && !paused && issued - start_count >= PHASE_REQS / 2) begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
            wait_drained();
            repeat (SETTLE_CYC) @(posedge i_clk);
        end

        repeat (40) @(posedge i_clk);
        if (errors == 0 && expected_boxes.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/rebf_pkg.sv
hw/rtl/rebf_row_store.sv
hw/rtl/rebf_grad.sv
hw/rtl/rebf_box.sv
hw/rtl/row_edge_box_finder_top.sv
tb/sv/testbench.sv
